[rtl/core/rss_pkg.sv]
`default_nettype none

package rss_pkg;

  // Operation carried in the mode field of an input word.
  typedef enum logic [1:0] {
    MODE_ACC    = 2'd0,
    MODE_REPORT = 2'd1,
    MODE_CLEAR  = 2'd2,
    MODE_IGNORE = 2'd3
  } rss_mode_t;

  localparam int MODE_W = 2;
  localparam int CNT_W  = 32;
  localparam int MARK_W = 32;
  localparam int STAT_W = 64;
  localparam int HALF_W = 32;

  // Queue status seen by the producer and the consumer.
  typedef struct packed {
    logic full;
    logic empty;
  } rss_qstat_t;

  // Divider status.
  typedef struct packed {
    logic busy;
    logic done;
  } rss_divstat_t;

endpackage

`default_nettype wire

[rtl/core/running_sample_statistics.sv]
// Path: an accepted accumulate or clear word passes the front register and the queue
//   before it reaches the statistics; a report ends in the output register.
// Throughput: one accumulate or clear word per cycle while the back end is idle;
//   a report holds it for the pop, six multiplier steps, then two divisions.
// Reset: synchronous, active low; empties the queue and clears all statistics at once.
`default_nettype none

module running_sample_statistics
  import rss_pkg::*;
#(
  parameter int SAMPLE_BITS = 32,
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [MODE_W-1:0] in_mode,
  input  wire logic [31:0]       in_sample,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [CNT_W-1:0]       out_event_count,
  output logic [STAT_W-1:0]      out_mean_value,
  output logic [STAT_W-1:0]      out_variance_value,
  output logic [MARK_W-1:0]      out_lowest_sample,
  output logic [MARK_W-1:0]      out_highest_sample
);

  // Each queued word holds the mode, the masked sample and its full square.
  localparam int QW = MODE_W + 3 * SAMPLE_BITS;

  // The front end registers each accepted word, drops words with the unused
  // mode, and forms the square of the sample so that the back end only adds.
  // It stalls the input only while its register is full and the queue is full.
  //
  // The back end takes one word a cycle from the queue while idle; accumulate
  // and clear finish in that cycle. A report with an empty count loads zeros
  // into the output register at once. Otherwise the variance numerator and
  // the squared count are built with one shared 32x32 multiplier over six
  // steps, all products taken modulo 2^64, and a shared restoring divider
  // then produces the mean and the variance, one quotient bit per cycle. A
  // report is started only while the output register is empty, so a waiting
  // result never blocks accumulate words from being consumed behind it.

  rss_qstat_t    q_stat;
  logic          push, pop;
  logic [QW-1:0] push_data, pop_data;

  rss_front #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .QW          (QW)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_mode   (in_mode),
    .in_sample (in_sample),
    .q_stat    (q_stat),
    .push      (push),
    .push_data (push_data)
  );

  rss_queue #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .q_stat    (q_stat)
  );

  rss_back #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .QW          (QW)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_stat             (q_stat),
    .pop_data           (pop_data),
    .pop                (pop),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_event_count    (out_event_count),
    .out_mean_value     (out_mean_value),
    .out_variance_value (out_variance_value),
    .out_lowest_sample  (out_lowest_sample),
    .out_highest_sample (out_highest_sample)
  );

endmodule

`default_nettype wire

[rtl/core/rss_front.sv]
`default_nettype none

module rss_front
  import rss_pkg::*;
#(
  parameter int SAMPLE_BITS = 32,
  parameter int QW          = MODE_W + 3 * SAMPLE_BITS
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [MODE_W-1:0]   in_mode,
  input  wire logic [31:0]         in_sample,
  input  wire rss_qstat_t          q_stat,
  output logic                     push,
  output logic [QW-1:0]            push_data
);

  logic                     fr_vld_r,    fr_vld_nxt;
  rss_mode_t                fr_mode_r;
  logic [SAMPLE_BITS-1:0]   fr_sample_r;
  logic [2*SAMPLE_BITS-1:0] fr_square_r;

  logic [SAMPLE_BITS-1:0]   sample_m;
  logic [2*SAMPLE_BITS-1:0] square_w;
  logic                     take;

  // Only the low sample bits take part; the square is formed here so the
  // back end only has to add.
  assign sample_m = in_sample[SAMPLE_BITS-1:0];
  assign square_w = sample_m * sample_m;

  assign in_stall  = fr_vld_r && q_stat.full;
  assign push      = fr_vld_r && !q_stat.full;
  assign take      = in_valid && !in_stall;
  assign push_data = {fr_mode_r, fr_sample_r, fr_square_r};

  // Words with the unused mode are dropped here and never reach the queue.
  always_comb begin
    fr_vld_nxt = fr_vld_r;
    if (!in_stall) begin
      fr_vld_nxt = in_valid && (rss_mode_t'(in_mode) != MODE_IGNORE);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_vld_r <= 1'b0;
    end else begin
      fr_vld_r <= fr_vld_nxt;
    end
    if (take) begin
      fr_mode_r   <= rss_mode_t'(in_mode);
      fr_sample_r <= sample_m;
      fr_square_r <= square_w;
    end
  end

endmodule

`default_nettype wire

[rtl/core/rss_queue.sv]
`default_nettype none

module rss_queue
  import rss_pkg::*;
#(
  parameter int WIDTH = 98,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] pop_data,
  output rss_qstat_t            q_stat
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r,    cnt_nxt;

  assign pop_data     = mem_r[rd_ptr_r];
  assign q_stat.full  = (cnt_r == CW'(DEPTH));
  assign q_stat.empty = (cnt_r == '0);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

[rtl/core/rss_divider.sv]
`default_nettype none

module rss_divider
  import rss_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [STAT_W-1:0] dividend,
  input  wire logic [STAT_W-1:0] divisor,
  output rss_divstat_t           stat,
  output logic      [STAT_W-1:0] quotient
);

  localparam int CNT_BITS = $clog2(STAT_W);

  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic [CNT_BITS-1:0] step_r, step_nxt;
  logic [STAT_W-1:0]   rem_r,  rem_nxt;
  logic [STAT_W-1:0]   quo_r,  quo_nxt;
  logic [STAT_W-1:0]   dvs_r,  dvs_nxt;

  logic [STAT_W:0]     rem_sh;
  logic [STAT_W+1:0]   diff;

  // Restoring division, one quotient bit per cycle, MSB first.
  assign rem_sh = {rem_r, quo_r[STAT_W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, dvs_r};

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = quo_r;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      if (!diff[STAT_W+1]) begin
        rem_nxt = diff[STAT_W-1:0];
        quo_nxt = {quo_r[STAT_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[STAT_W-1:0];
        quo_nxt = {quo_r[STAT_W-2:0], 1'b0};
      end
      step_nxt = step_r + 1'b1;
      if (step_r == CNT_BITS'(STAT_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

endmodule

`default_nettype wire

[rtl/core/rss_back.sv]
`default_nettype none

module rss_back
  import rss_pkg::*;
#(
  parameter int SAMPLE_BITS = 32,
  parameter int QW          = MODE_W + 3 * SAMPLE_BITS
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire rss_qstat_t        q_stat,
  input  wire logic [QW-1:0]     pop_data,
  output logic                   pop,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [CNT_W-1:0]       out_event_count,
  output logic [STAT_W-1:0]      out_mean_value,
  output logic [STAT_W-1:0]      out_variance_value,
  output logic [MARK_W-1:0]      out_lowest_sample,
  output logic [MARK_W-1:0]      out_highest_sample
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV_MEAN,
    ST_DIV_VAR
  } st_t;

  // Steps of the shared multiplier while the variance numerator is built.
  localparam logic [2:0] MS_SQ_LO  = 3'd0;
  localparam logic [2:0] MS_SQ_HI  = 3'd1;
  localparam logic [2:0] MS_SU_LL  = 3'd2;
  localparam logic [2:0] MS_SU_LH  = 3'd3;
  localparam logic [2:0] MS_CNT_SQ = 3'd4;
  localparam logic [2:0] MS_DONE   = 3'd5;

  st_t               state_r,   state_nxt;
  logic [2:0]        mstep_r,   mstep_nxt;
  logic [CNT_W-1:0]  cnt_r,     cnt_nxt;
  logic [STAT_W-1:0] sum_r,     sum_nxt;
  logic [STAT_W-1:0] sqsum_r,   sqsum_nxt;
  logic [MARK_W-1:0] low_r,     low_nxt;
  logic [MARK_W-1:0] high_r,    high_nxt;
  logic [STAT_W-1:0] prod_r,    prod_nxt;
  logic [STAT_W-1:0] num_r,     num_nxt;
  logic [STAT_W-1:0] den_r,     den_nxt;
  logic [STAT_W-1:0] mean_r,    mean_nxt;
  logic              out_vld_r, out_vld_nxt;
  logic [CNT_W-1:0]  o_cnt_r,   o_cnt_nxt;
  logic [STAT_W-1:0] o_mean_r,  o_mean_nxt;
  logic [STAT_W-1:0] o_var_r,   o_var_nxt;
  logic [MARK_W-1:0] o_low_r,   o_low_nxt;
  logic [MARK_W-1:0] o_high_r,  o_high_nxt;

  rss_mode_t         hd_mode;
  logic [MARK_W-1:0] hd_sample;
  logic [STAT_W-1:0] hd_square;
  logic [HALF_W-1:0] mul_a, mul_b;
  logic              div_start;
  logic [STAT_W-1:0] div_dividend, div_divisor, div_quotient;
  rss_divstat_t      div_stat;

  assign hd_mode   = rss_mode_t'(pop_data[QW-1 -: MODE_W]);
  assign hd_sample = MARK_W'(pop_data[2*SAMPLE_BITS +: SAMPLE_BITS]);
  assign hd_square = STAT_W'(pop_data[2*SAMPLE_BITS-1:0]);

  assign prod_nxt = mul_a * mul_b;

  // The mean goes through the divider first, then the variance.
  assign div_dividend = (state_r == ST_MUL) ? sum_r : num_r;
  assign div_divisor  = (state_r == ST_MUL) ? STAT_W'(cnt_r) : den_r;

  rss_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .stat     (div_stat),
    .quotient (div_quotient)
  );

  always_comb begin
    state_nxt   = state_r;
    mstep_nxt   = mstep_r;
    cnt_nxt     = cnt_r;
    sum_nxt     = sum_r;
    sqsum_nxt   = sqsum_r;
    low_nxt     = low_r;
    high_nxt    = high_r;
    num_nxt     = num_r;
    den_nxt     = den_r;
    mean_nxt    = mean_r;
    out_vld_nxt = out_vld_r;
    o_cnt_nxt   = o_cnt_r;
    o_mean_nxt  = o_mean_r;
    o_var_nxt   = o_var_r;
    o_low_nxt   = o_low_r;
    o_high_nxt  = o_high_r;
    pop         = 1'b0;
    div_start   = 1'b0;
    mul_a       = cnt_r;
    mul_b       = cnt_r;

    if (out_vld_r && !out_stall) begin
      out_vld_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (!q_stat.empty) begin
          case (hd_mode)
            MODE_ACC: begin
              pop = 1'b1;
              if (cnt_r != '1) begin
                cnt_nxt = cnt_r + 1'b1;
              end
              sum_nxt   = sum_r + STAT_W'(hd_sample);
              sqsum_nxt = sqsum_r + hd_square;
              if (hd_sample < low_r) begin
                low_nxt = hd_sample;
              end
              if (hd_sample > high_r) begin
                high_nxt = hd_sample;
              end
            end
            MODE_CLEAR: begin
              pop       = 1'b1;
              cnt_nxt   = '0;
              sum_nxt   = '0;
              sqsum_nxt = '0;
              low_nxt   = '1;
              high_nxt  = '0;
            end
            MODE_REPORT: begin
              // A report waits until the output register is free.
              if (!out_vld_r) begin
                pop = 1'b1;
                if (cnt_r == '0) begin
                  out_vld_nxt = 1'b1;
                  o_cnt_nxt   = '0;
                  o_mean_nxt  = '0;
                  o_var_nxt   = '0;
                  o_low_nxt   = '0;
                  o_high_nxt  = '0;
                end else begin
                  state_nxt = ST_MUL;
                  mstep_nxt = MS_SQ_LO;
                  num_nxt   = '0;
                end
              end
            end
            default: begin
              pop = 1'b1;
            end
          endcase
        end
      end
      ST_MUL: begin
        // Each product is registered and folded in on the following step.
        mstep_nxt = mstep_r + 1'b1;
        case (mstep_r)
          MS_SQ_LO: begin
            mul_a = sqsum_r[HALF_W-1:0];
            mul_b = cnt_r;
          end
          MS_SQ_HI: begin
            num_nxt = num_r + prod_r;
            mul_a   = sqsum_r[STAT_W-1:HALF_W];
            mul_b   = cnt_r;
          end
          MS_SU_LL: begin
            num_nxt = num_r + {prod_r[HALF_W-1:0], {HALF_W{1'b0}}};
            mul_a   = sum_r[HALF_W-1:0];
            mul_b   = sum_r[HALF_W-1:0];
          end
          MS_SU_LH: begin
            num_nxt = num_r - prod_r;
            mul_a   = sum_r[HALF_W-1:0];
            mul_b   = sum_r[STAT_W-1:HALF_W];
          end
          MS_CNT_SQ: begin
            num_nxt = num_r - {prod_r[HALF_W-2:0], {(HALF_W + 1){1'b0}}};
            mul_a   = cnt_r;
            mul_b   = cnt_r;
          end
          MS_DONE: begin
            den_nxt   = prod_r;
            div_start = 1'b1;
            state_nxt = ST_DIV_MEAN;
          end
          default: begin
            state_nxt = ST_IDLE;
          end
        endcase
      end
      ST_DIV_MEAN: begin
        if (div_stat.done) begin
          mean_nxt  = div_quotient;
          div_start = 1'b1;
          state_nxt = ST_DIV_VAR;
        end
      end
      ST_DIV_VAR: begin
        if (div_stat.done) begin
          out_vld_nxt = 1'b1;
          o_cnt_nxt   = cnt_r;
          o_mean_nxt  = mean_r;
          o_var_nxt   = div_quotient;
          o_low_nxt   = low_r;
          o_high_nxt  = high_r;
          state_nxt   = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      mstep_r   <= MS_SQ_LO;
      out_vld_r <= 1'b0;
      cnt_r     <= '0;
      sum_r     <= '0;
      sqsum_r   <= '0;
      low_r     <= '1;
      high_r    <= '0;
    end else begin
      state_r   <= state_nxt;
      mstep_r   <= mstep_nxt;
      out_vld_r <= out_vld_nxt;
      cnt_r     <= cnt_nxt;
      sum_r     <= sum_nxt;
      sqsum_r   <= sqsum_nxt;
      low_r     <= low_nxt;
      high_r    <= high_nxt;
    end
    prod_r   <= prod_nxt;
    num_r    <= num_nxt;
    den_r    <= den_nxt;
    mean_r   <= mean_nxt;
    o_cnt_r  <= o_cnt_nxt;
    o_mean_r <= o_mean_nxt;
    o_var_r  <= o_var_nxt;
    o_low_r  <= o_low_nxt;
    o_high_r <= o_high_nxt;
  end

  assign out_valid          = out_vld_r;
  assign out_event_count    = o_cnt_r;
  assign out_mean_value     = o_mean_r;
  assign out_variance_value = o_var_r;
  assign out_lowest_sample  = o_low_r;
  assign out_highest_sample = o_high_r;

  a_busy_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !out_vld_r)
    else $error("report in progress while output register is occupied");

  a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_stat.busy)
    else $error("divider started while busy");

  a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_stat.empty)
    else $error("queue popped while empty");

  a_var_done_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV_VAR && div_stat.done) |=> (out_vld_r && state_r == ST_IDLE))
    else $error("finished report did not reach the output register");

endmodule

`default_nettype wire
